[rtl/lirs_pkg.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared widths, register map, payload types and control bundles.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = 24;
  localparam int PHASE_W     = STEP_W + 1;
  localparam int CH_W        = 2;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [PHASE_W-1:0] ONE_Q      = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_MIN   = STEP_W'(2048);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0]    CH_RESET   = CH_W'(2);
  localparam logic [CH_W-1:0]    CH_MONO    = CH_W'(1);

  localparam logic REG_STEP     = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          run_last;
    logic                          sound_end;
  } out_item_t;

  typedef struct packed {
    logic mono;
    logic run_last;
    logic sound_end;
  } emit_ctrl_t;

endpackage

[rtl/lirs_lane.sv]
// ----------------------------------------------------------------------------
// Resampler interpolation lane
// Blends one channel between the held and the new sample at a fractional
// phase with round to nearest, or passes the new sample through.
// ----------------------------------------------------------------------------
module lirs_lane (
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] a_i,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] b_i,
  input  logic        [lirs_pkg::FRAC_BITS-1:0]   frac_i,
  input  logic                                    hold_i,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0] y_o
);

  localparam int S      = lirs_pkg::SAMPLE_BITS;
  localparam int F      = lirs_pkg::FRAC_BITS;
  localparam int PROD_W = S + F + 2;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - F;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (F - 1);
  localparam logic signed [Q_W-1:0] QMAX = {{(Q_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [Q_W-1:0] QMIN = {{(Q_W-S+1){1'b1}}, {(S-1){1'b0}}};

  logic signed [S:0]         diff;
  logic signed [F:0]         frac_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   a_ext;
  logic signed [SUM_W-1:0]   sum;
  logic signed [Q_W-1:0]     q;
  logic signed [S-1:0]       blend;

  assign diff   = {b_i[S-1], b_i} - {a_i[S-1], a_i};
  assign frac_s = $signed({1'b0, frac_i});
  assign prod   = PROD_W'(diff) * PROD_W'(frac_s);
  assign a_ext  = {{(SUM_W-S-F){a_i[S-1]}}, a_i, {F{1'b0}}};
  assign sum    = a_ext + SUM_W'(prod) + HALF;
  assign q      = sum[SUM_W-1:F];

  always_comb begin
    if (q > QMAX) begin
      blend = QMAX[S-1:0];
    end else if (q < QMIN) begin
      blend = QMIN[S-1:0];
    end else begin
      blend = q[S-1:0];
    end
  end

  assign y_o = hold_i ? b_i : blend;

endmodule

[rtl/lirs_merge.sv]
// ----------------------------------------------------------------------------
// Resampler output merge stage
// Combines the lane results and flags into the registered output transfer.
// ----------------------------------------------------------------------------
module lirs_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    emit_i,
  input  lirs_pkg::emit_ctrl_t                    ctrl_i,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] left_i,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] right_i,
  output logic                                    free_o,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output lirs_pkg::out_item_t                     out_data
);

  logic                 out_valid_r;
  lirs_pkg::out_item_t  out_data_r;

  assign free_o = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_i) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_i) begin
      out_data_r.left_out  <= left_i;
      out_data_r.right_out <= ctrl_i.mono ? '0 : right_i;
      out_data_r.run_last  <= ctrl_i.run_last;
      out_data_r.sound_end <= ctrl_i.sound_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/linear_interp_resampler_core.sv]
// Each input item is registered in the sequencer, and each result in the merge output register.
// Results leave at one result per cycle from the two channel lanes while the output is not
// stalled; an item may also produce no results.
// A new input is taken only once every result of the previous item is in the output register.
// Reset is synchronous and active low; it sets step to 1.0, stereo mode and no held frame.
// ----------------------------------------------------------------------------
// Linear interpolation resampler core
// Sequencer, configuration registers, two channel lanes and the output merge.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lirs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lirs_pkg::out_item_t             out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lirs_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [lirs_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [lirs_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int S  = lirs_pkg::SAMPLE_BITS;
  localparam int F  = lirs_pkg::FRAC_BITS;
  localparam int PW = lirs_pkg::PHASE_W;
  localparam int SW = lirs_pkg::STEP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_HOLD
  } state_t;

  state_t                   state_r;
  logic [SW-1:0]            step_r;
  logic [lirs_pkg::CH_W-1:0] channels_r;
  logic [PW-1:0]            phase_r;
  logic                     have_held_r;
  logic                     last_r;
  logic signed [S-1:0]      held_l_r;
  logic signed [S-1:0]      held_rt_r;
  logic signed [S-1:0]      new_l_r;
  logic signed [S-1:0]      new_rt_r;

  logic                     cfg_wr;
  logic                     in_xfer;
  logic                     out_free;
  logic                     emit_go;
  logic [SW-1:0]            step_eff;
  logic [PW-1:0]            phase_add;
  logic [PW-1:0]            phase_sub;
  logic [PW-1:0]            phase_skip;
  logic                     add_below;
  logic                     sub_below;
  logic                     skip_below;
  lirs_pkg::emit_ctrl_t     ctrl;
  logic signed [S-1:0]      lane_l;
  logic signed [S-1:0]      lane_rt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= lirs_pkg::STEP_RESET;
      channels_r <= lirs_pkg::CH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        lirs_pkg::REG_STEP:     step_r     <= cfg_pwdata[SW-1:0];
        lirs_pkg::REG_CHANNELS: channels_r <= cfg_pwdata[lirs_pkg::CH_W-1:0];
        default:                step_r     <= step_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      lirs_pkg::REG_STEP:     cfg_prdata = lirs_pkg::DATA_W'(step_r);
      lirs_pkg::REG_CHANNELS: cfg_prdata = lirs_pkg::DATA_W'(channels_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign emit_go  = (state_r != ST_IDLE) && out_free;

  assign step_eff   = (step_r < lirs_pkg::STEP_MIN) ? lirs_pkg::STEP_MIN : step_r;
  assign phase_add  = phase_r + PW'(step_eff);
  assign phase_sub  = phase_add - lirs_pkg::ONE_Q;
  assign phase_skip = phase_r - lirs_pkg::ONE_Q;
  assign add_below  = phase_add < lirs_pkg::ONE_Q;
  assign sub_below  = phase_sub < lirs_pkg::ONE_Q;
  assign skip_below = phase_skip < lirs_pkg::ONE_Q;

  always_comb begin
    ctrl.mono = (channels_r == lirs_pkg::CH_MONO);
    if (state_r == ST_HOLD) begin
      ctrl.run_last  = !add_below;
      ctrl.sound_end = !add_below;
    end else begin
      ctrl.run_last  = !add_below && !(last_r && sub_below);
      ctrl.sound_end = !add_below && !(last_r && sub_below) && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      have_held_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            new_l_r  <= in_data.left_sample;
            new_rt_r <= in_data.right_sample;
            last_r   <= in_data.last_frame;
            if (!have_held_r) begin
              held_l_r    <= in_data.left_sample;
              held_rt_r   <= in_data.right_sample;
              have_held_r <= 1'b1;
              phase_r     <= '0;
              if (in_data.last_frame) begin
                state_r <= ST_HOLD;
              end
            end else if (phase_r < lirs_pkg::ONE_Q) begin
              state_r <= ST_INTERP;
            end else begin
              held_l_r  <= in_data.left_sample;
              held_rt_r <= in_data.right_sample;
              if (in_data.last_frame && skip_below) begin
                phase_r <= phase_skip;
                state_r <= ST_HOLD;
              end else if (in_data.last_frame) begin
                phase_r     <= '0;
                have_held_r <= 1'b0;
              end else begin
                phase_r <= phase_skip;
              end
            end
          end
        end
        ST_INTERP: begin
          if (emit_go) begin
            if (add_below) begin
              phase_r <= phase_add;
            end else begin
              held_l_r  <= new_l_r;
              held_rt_r <= new_rt_r;
              if (last_r && sub_below) begin
                phase_r <= phase_sub;
                state_r <= ST_HOLD;
              end else if (last_r) begin
                phase_r     <= '0;
                have_held_r <= 1'b0;
                state_r     <= ST_IDLE;
              end else begin
                phase_r <= phase_sub;
                state_r <= ST_IDLE;
              end
            end
          end
        end
        ST_HOLD: begin
          if (emit_go) begin
            if (add_below) begin
              phase_r <= phase_add;
            end else begin
              phase_r     <= '0;
              have_held_r <= 1'b0;
              state_r     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  lirs_lane u_lane_left (
    .a_i    (held_l_r),
    .b_i    (new_l_r),
    .frac_i (phase_r[F-1:0]),
    .hold_i (state_r == ST_HOLD),
    .y_o    (lane_l)
  );

  lirs_lane u_lane_right (
    .a_i    (held_rt_r),
    .b_i    (new_rt_r),
    .frac_i (phase_r[F-1:0]),
    .hold_i (state_r == ST_HOLD),
    .y_o    (lane_rt)
  );

  lirs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_i    (emit_go),
    .ctrl_i    (ctrl),
    .left_i    (lane_l),
    .right_i   (lane_rt),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (phase_r < lirs_pkg::ONE_Q))
    else $error("phase out of range while emitting");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && ctrl.sound_end) |=> (state_r == ST_IDLE && !have_held_r))
    else $error("sequencer did not reset after the end of a sound");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> out_free)
    else $error("result issued into an occupied output register");

  a_mono_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && ctrl.mono) |=> (out_data.right_out == '0))
    else $error("right channel not cleared in mono mode");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && ctrl.sound_end) |-> ctrl.run_last)
    else $error("sound end flagged on a result that is not the last of its transfer");
`endif

endmodule
